>>> rtl/work_stealing_lane_queues_macros.svh
// Assertion macros used by the checker file.
`ifndef WORK_STEALING_LANE_QUEUES_MACROS_SVH
`define WORK_STEALING_LANE_QUEUES_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define WSLQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define WSLQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wslq_pkg.sv
package wslq_pkg;

  localparam int NUM_LANES_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 256;

  localparam int JOB_W  = 64;
  localparam int LANE_W = 4;
  localparam int CFG_W  = 5;
  localparam int STAT_W = 2;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd8;

  localparam logic [63:0] RNG_MULT  = 64'h2545_F491_4F6C_DD1D;
  localparam logic [63:0] SEED_BASE = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SEED_STEP = 64'h0F1E_2D3C_4B5A_6978;

  localparam int XS_SHIFT_A = 12;
  localparam int XS_SHIFT_B = 25;
  localparam int XS_SHIFT_C = 27;

  // Bits of the dividend retired per cycle by the remainder unit.
  localparam int MOD_BITS = 4;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BAD_LANE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RAND,
    S_SWEEP,
    S_READ
  } ctrl_state_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_MOD,
    U_DONE
  } unit_phase_t;

  function automatic logic [63:0] xorshift_step(input logic [63:0] s);
    logic [63:0] v;
    v = s ^ (s >> XS_SHIFT_A);
    v = v ^ (v << XS_SHIFT_B);
    v = v ^ (v >> XS_SHIFT_C);
    return v;
  endfunction

  function automatic logic [63:0] seed_for(input int unsigned i);
    return SEED_BASE + 64'(i) * SEED_STEP;
  endfunction

endpackage

>>> rtl/wslq_ram.sv
module wslq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/wslq_rng_unit.sv
module wslq_rng_unit #(
  parameter int NUM_LANES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [63:0]                    seed,
  input  logic [$clog2(NUM_LANES+1)-1:0] divisor,
  output logic                           done,
  output logic [$clog2(NUM_LANES)-1:0]   pick
);

  import wslq_pkg::*;

  localparam int CW        = $clog2(NUM_LANES + 1);
  localparam int LW        = $clog2(NUM_LANES);
  localparam int MOD_STEPS = 64 / MOD_BITS;
  localparam int STEP_W    = $clog2(MOD_STEPS);

  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_TWO = STEP_W'(2);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(3);
  localparam logic [STEP_W-1:0] MOD_LAST = STEP_W'(MOD_STEPS - 1);

  unit_phase_t       phase_r, phase_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [63:0]       seed_r;
  logic [63:0]       prod_r;
  logic [63:0]       acc_r;
  logic [63:0]       acc_mul_nxt;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_p;
  logic [CW-1:0]     div_r;
  logic [CW-1:0]     rem_r, rem_nxt;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      U_IDLE: begin
        if (start) phase_nxt = U_MUL;
      end
      U_MUL: begin
        if (step_r == MUL_LAST) phase_nxt = U_MOD;
      end
      U_MOD: begin
        if (step_r == MOD_LAST) phase_nxt = U_DONE;
      end
      U_DONE: begin
        phase_nxt = U_IDLE;
      end
      default: begin
        phase_nxt = U_IDLE;
      end
    endcase
  end

  // Phase outputs
  always_comb begin
    done = 1'b0;
    case (phase_r)
      U_DONE:  done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  assign step_nxt = (phase_nxt != phase_r) ? '0 : step_r + 1'b1;

  // Low 64 bits of seed * multiplier from three 32x32 partial products
  assign mul_a = (step_r == STEP_ONE) ? seed_r[63:32] : seed_r[31:0];
  assign mul_b = (step_r == STEP_TWO) ? RNG_MULT[63:32] : RNG_MULT[31:0];
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  assign acc_mul_nxt = (step_r == STEP_ONE) ? prod_r
                                            : {acc_r[63:32] + prod_r[31:0], acc_r[31:0]};

  // Restoring remainder, MOD_BITS dividend bits per cycle
  always_comb begin
    logic [CW:0]   trial;
    logic [CW-1:0] rem_w;
    rem_w = rem_r;
    for (int k = 0; k < MOD_BITS; k++) begin
      trial = {rem_w, acc_r[63-k]};
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      rem_w = trial[CW-1:0];
    end
    rem_nxt = rem_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= U_IDLE;
      step_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == U_IDLE && start) begin
      seed_r <= seed;
      div_r  <= divisor;
    end
    if (phase_r == U_MUL) begin
      prod_r <= mul_p;
      rem_r  <= '0;
      if (step_r != '0) begin
        acc_r <= acc_mul_nxt;
      end
    end
    if (phase_r == U_MOD) begin
      acc_r <= acc_r << MOD_BITS;
      rem_r <= rem_nxt;
    end
  end

  assign pick = LW'(rem_r);

endmodule

>>> rtl/work_stealing_lane_queues.sv
// Per-lane bounded job queues with random-start work stealing. Each lane owns
// a FIFO of QUEUE_DEPTH 64-bit job words held in one shared RAM. A push
// (req_type 0) appends in_job_word to the lane's FIFO and answers done or
// queue full. An acquire (req_type 1) pops the lane's own FIFO first; when that
// is empty and more than one lane is active, the lane's xorshift64* generator
// advances, its output modulo the active lane count picks a start lane, and
// the lanes are swept upward from there (wrapping, skipping the requester)
// until a non-empty FIFO gives up its oldest job. A lane at or above the active
// lane count gets a bad lane status and changes nothing. cfg_data sets the
// active lane count (clamped to 1..NUM_LANES, reset 8); write it only while
// the block is idle. One request is processed at a time and in_ready is low
// while it runs. A push or a rejected request is answered from the dispatch
// state; a pop of the own queue reads the RAM there and is answered from the
// read state. A steal runs the 64-bit multiply through one 32x32 multiplier,
// reduces the product modulo the lane count four bits at a time, and then
// sweeps the lanes from the start lane, probing one lane per cycle. No
// clearing pass is needed after reset: queue pointers reset, and a RAM word
// is only read after a push has written it. The result sits in an output
// register, so a new request is taken while a result still waits.
module work_stealing_lane_queues #(
  parameter int NUM_LANES   = wslq_pkg::NUM_LANES_DEF,
  parameter int QUEUE_DEPTH = wslq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [wslq_pkg::LANE_W-1:0] in_lane,
  input  logic [wslq_pkg::JOB_W-1:0]  in_job_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wslq_pkg::STAT_W-1:0] out_status,
  output logic [wslq_pkg::JOB_W-1:0]  out_got_job,
  output logic [wslq_pkg::LANE_W-1:0] out_source_lane,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wslq_pkg::CFG_W-1:0]  cfg_data
);

  import wslq_pkg::*;

  localparam int LW        = $clog2(NUM_LANES);
  localparam int CW        = $clog2(NUM_LANES + 1);
  localparam int SW        = $clog2(QUEUE_DEPTH);
  localparam int PW        = SW + 1;
  localparam int AW        = LW + SW;
  localparam int RAM_DEPTH = NUM_LANES * (2 ** SW);
  localparam int CMPW      = (CW > CFG_W) ? CW : CFG_W;

  localparam logic [PW-1:0]   DEPTH_P  = PW'(QUEUE_DEPTH);
  localparam logic [PW-1:0]   PTR_LAST = PW'(2 * QUEUE_DEPTH - 1);
  localparam logic [CMPW-1:0] LANES_C  = CMPW'(NUM_LANES);
  localparam logic [CMPW-1:0] ONE_C    = CMPW'(1);
  localparam logic [CMPW-1:0] TWO_C    = CMPW'(2);

  // Pointers run modulo twice the depth so full and empty stay distinct.
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  ctrl_state_t state_r, state_nxt;

  logic [CFG_W-1:0]  active_lanes_r;
  logic              req_r;
  logic [LANE_W-1:0] lane_r;
  logic [JOB_W-1:0]  job_r;

  logic [PW-1:0] head_r [NUM_LANES];
  logic [PW-1:0] tail_r [NUM_LANES];
  logic [63:0]   rng_r  [NUM_LANES];

  logic [LW-1:0] idx_r;
  logic [LW-1:0] src_r;
  logic [CW-1:0] cnt_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [JOB_W-1:0]  out_got_job_r;
  logic [LANE_W-1:0] out_source_lane_r;

  // Decode
  logic [CMPW-1:0] act_ext;
  logic [CMPW-1:0] count_ext;
  logic [CW-1:0]   count;
  logic            lane_ok;
  logic            count_lt2;
  logic [LW-1:0]   lane_ix;
  logic [LW-1:0]   tbl_ix;
  logic [PW-1:0]   head_q;
  logic [PW-1:0]   tail_q;
  logic [PW-1:0]   occ_abs;
  logic            q_empty;
  logic            q_full;
  logic [SW-1:0]   slot_h;
  logic [SW-1:0]   slot_t;
  logic [63:0]     rng_adv;
  logic            can_emit;
  logic            sweep_end;
  logic            is_victim;
  logic [LW-1:0]   idx_wrap;

  // Sequencer strobes
  logic    do_emit;
  status_t emit_status;
  logic    emit_from_ram;
  logic    ram_we;
  logic    ram_re;
  logic    head_inc;
  logic    tail_inc;
  logic    rng_we;
  logic    unit_start;
  logic    sweep_load;
  logic    sweep_adv;

  logic             unit_done;
  logic [LW-1:0]    unit_pick;
  logic [JOB_W-1:0] ram_rdata;

  // Clamp the lane count to 1..NUM_LANES
  assign act_ext   = CMPW'(active_lanes_r);
  assign count_ext = (act_ext == '0) ? ONE_C : ((act_ext > LANES_C) ? LANES_C : act_ext);
  assign count     = CW'(count_ext);
  assign count_lt2 = count_ext < TWO_C;
  assign lane_ok   = CMPW'(lane_r) < count_ext;
  assign lane_ix   = LW'(lane_r);

  // One table port: the requester's lane, or the lane under the sweep
  assign tbl_ix  = (state_r == S_SWEEP) ? idx_r : lane_ix;
  assign head_q  = head_r[tbl_ix];
  assign tail_q  = tail_r[tbl_ix];
  assign occ_abs = (tail_q >= head_q) ? tail_q - head_q : head_q - tail_q;
  assign q_empty = (head_q == tail_q);
  assign q_full  = (occ_abs == DEPTH_P);
  assign slot_h  = SW'((head_q >= DEPTH_P) ? head_q - DEPTH_P : head_q);
  assign slot_t  = SW'((tail_q >= DEPTH_P) ? tail_q - DEPTH_P : tail_q);

  assign rng_adv = xorshift_step(rng_r[lane_ix]);

  assign can_emit  = !out_valid_r || out_ready;
  assign sweep_end = (cnt_r == count);
  assign is_victim = (idx_r != lane_ix) && !q_empty;
  assign idx_wrap  = (CW'(idx_r) == count - 1'b1) ? '0 : idx_r + 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (!lane_ok || !req_r) begin
          if (can_emit) state_nxt = S_IDLE;
        end else if (!q_empty) begin
          state_nxt = S_READ;
        end else if (count_lt2) begin
          if (can_emit) state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RAND;
        end
      end
      S_RAND: begin
        if (unit_done) state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        if (sweep_end) begin
          if (can_emit) state_nxt = S_IDLE;
        end else if (is_victim) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (can_emit) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    do_emit       = 1'b0;
    emit_status   = ST_DONE;
    emit_from_ram = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    head_inc      = 1'b0;
    tail_inc      = 1'b0;
    rng_we        = 1'b0;
    unit_start    = 1'b0;
    sweep_load    = 1'b0;
    sweep_adv     = 1'b0;
    case (state_r)
      S_DISPATCH: begin
        if (!lane_ok) begin
          do_emit     = can_emit;
          emit_status = ST_BAD_LANE;
        end else if (!req_r) begin
          // Push: commit only together with the result
          do_emit     = can_emit;
          emit_status = q_full ? ST_FULL : ST_DONE;
          ram_we      = can_emit && !q_full;
          tail_inc    = can_emit && !q_full;
        end else if (!q_empty) begin
          ram_re   = 1'b1;
          head_inc = 1'b1;
        end else if (count_lt2) begin
          do_emit     = can_emit;
          emit_status = ST_EMPTY;
        end else begin
          rng_we     = 1'b1;
          unit_start = 1'b1;
        end
      end
      S_RAND: begin
        sweep_load = unit_done;
      end
      S_SWEEP: begin
        if (sweep_end) begin
          do_emit     = can_emit;
          emit_status = ST_EMPTY;
        end else if (is_victim) begin
          ram_re   = 1'b1;
          head_inc = 1'b1;
        end else begin
          sweep_adv = 1'b1;
        end
      end
      S_READ: begin
        do_emit       = can_emit;
        emit_status   = ST_DONE;
        emit_from_ram = 1'b1;
      end
      default: begin
        do_emit = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      active_lanes_r <= ACTIVE_RESET;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        rng_r[i]  <= seed_for(i);
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        active_lanes_r <= cfg_data;
      end
      if (do_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (head_inc) begin
        head_r[tbl_ix] <= ptr_inc(head_q);
      end
      if (tail_inc) begin
        tail_r[lane_ix] <= ptr_inc(tail_q);
      end
      if (rng_we) begin
        rng_r[lane_ix] <= rng_adv;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r  <= in_req_type;
      lane_r <= in_lane;
      job_r  <= in_job_word;
    end
    if (head_inc) begin
      src_r <= tbl_ix;
    end
    if (sweep_load) begin
      idx_r <= unit_pick;
      cnt_r <= '0;
    end else if (sweep_adv) begin
      idx_r <= idx_wrap;
      cnt_r <= cnt_r + 1'b1;
    end
    if (do_emit) begin
      out_status_r      <= emit_status;
      out_got_job_r     <= emit_from_ram ? ram_rdata : '0;
      out_source_lane_r <= emit_from_ram ? LANE_W'(src_r) : '0;
    end
  end

  // Random start lane: multiply and remainder on one iterative unit
  wslq_rng_unit #(
    .NUM_LANES (NUM_LANES)
  ) u_rng_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (unit_start),
    .seed    (rng_adv),
    .divisor (count),
    .done    (unit_done),
    .pick    (unit_pick)
  );

  // Job words of all lanes, addressed by {lane, slot}
  wslq_ram #(
    .WIDTH (JOB_W),
    .DEPTH (RAM_DEPTH)
  ) u_job_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (AW'({lane_ix, slot_t})),
    .wr_data (job_r),
    .rd_en   (ram_re),
    .rd_addr (AW'({tbl_ix, slot_h})),
    .rd_data (ram_rdata)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_got_job     = out_got_job_r;
  assign out_source_lane = out_source_lane_r;

endmodule

>>> rtl/wslq_checker.sv
`include "work_stealing_lane_queues_macros.svh"

module wslq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_req_type,
  input logic [wslq_pkg::LANE_W-1:0] in_lane,
  input logic [wslq_pkg::JOB_W-1:0]  in_job_word,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [wslq_pkg::STAT_W-1:0] out_status,
  input logic [wslq_pkg::JOB_W-1:0]  out_got_job,
  input logic [wslq_pkg::LANE_W-1:0] out_source_lane,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [wslq_pkg::CFG_W-1:0]  cfg_data
);

  import wslq_pkg::*;

  // A stalled result holds its job word
  `WSLQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_got_job), "stalled result changed")

  // Only a successful acquire carries a job and a source lane
  `WSLQ_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && out_status != ST_DONE, out_got_job == '0 && out_source_lane == '0, "failed request carries a job")

  // One request at a time: the input closes right after a transaction
  `WSLQ_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "input open while busy")

  // A new result appears only as the sequencer returns to idle
  `WSLQ_ASSERT_NOW(a_result_idle, clk, rst_n, $rose(out_valid), in_ready, "result without return to idle")

endmodule

bind work_stealing_lane_queues wslq_checker u_wslq_checker (.*);

>>> dv/tb_work_stealing_lane_queues.sv
`timescale 1ns / 100ps

module tb_work_stealing_lane_queues;

  localparam int LANES = 16;
  localparam int DEPTH = 256;

  // Generator constants, kept here so a wrong value in the design shows up.
  localparam logic [63:0] STEAL_MULT = 64'h2545_F491_4F6C_DD1D;
  localparam logic [63:0] SEED_FIRST = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SEED_DELTA = 64'h0F1E_2D3C_4B5A_6978;

  localparam int LONG_HOLD_CYCLES = 400;

  typedef enum logic {
    REQ_PUSH    = 1'b0,
    REQ_ACQUIRE = 1'b1
  } req_kind_t;

  typedef struct packed {
    wslq_pkg::status_t status;
    logic [63:0]       job;
    logic [3:0]        src;
  } lane_result_t;

  // Mirror of the per-lane job queues and steal generators; holds the results
  // still owed by the block, oldest first.
  class lane_queue_scoreboard;
    logic [63:0]  lane_jobs [LANES][$];
    logic [63:0]  steal_rng [LANES];
    logic [4:0]   lanes_reg;
    lane_result_t owed_results [$];
    int           mismatches;
    int           status_seen [4];
    int           steals;

    function new();
      for (int i = 0; i < LANES; i++) begin
        lane_jobs[i].delete();
        steal_rng[i] = SEED_FIRST + 64'(i) * SEED_DELTA;
      end
      lanes_reg  = 5'd8;
      mismatches = 0;
      steals     = 0;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
    endfunction

    function int unsigned live_lanes();
      if (lanes_reg < 5'd1) return 1;
      if (lanes_reg > 5'(LANES)) return LANES;
      return int'(lanes_reg);
    endfunction

    function void set_lanes(logic [4:0] v);
      lanes_reg = v;
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction

    // Advance one lane's xorshift64* generator and return its scrambled output.
    function logic [63:0] next_draw(int unsigned q);
      logic [63:0] s;
      s = steal_rng[q];
      s = s ^ (s >> 12);
      s = s ^ (s << 25);
      s = s ^ (s >> 27);
      steal_rng[q] = s;
      return s * STEAL_MULT;
    endfunction

    function lane_result_t predict(req_kind_t kind, logic [3:0] ln, logic [63:0] jw);
      lane_result_t r;
      int unsigned  count;
      int unsigned  start;
      int unsigned  v;
      logic [63:0]  draw;
      count = live_lanes();
      r.status = wslq_pkg::ST_DONE;
      r.job    = '0;
      r.src    = '0;
      if (int'(ln) >= count) begin
        r.status = wslq_pkg::ST_BAD_LANE;
      end else if (kind == REQ_PUSH) begin
        if (lane_jobs[ln].size() >= DEPTH) begin
          r.status = wslq_pkg::ST_FULL;
        end else begin
          lane_jobs[ln].push_back(jw);
        end
      end else if (lane_jobs[ln].size() > 0) begin
        r.job = lane_jobs[ln].pop_front();
        r.src = ln;
      end else if (count < 2) begin
        r.status = wslq_pkg::ST_EMPTY;
      end else begin
        // Steal: random start, sweep upward with wrap, skip the requester.
        draw  = next_draw(ln);
        start = int'(draw % 64'(count));
        r.status = wslq_pkg::ST_EMPTY;
        for (int i = 0; i < count; i++) begin
          v = (start + i) % count;
          if (v == ln) continue;
          if (lane_jobs[v].size() > 0) begin
            r.status = wslq_pkg::ST_DONE;
            r.job    = lane_jobs[v].pop_front();
            r.src    = 4'(v);
            steals++;
            break;
          end
        end
      end
      return r;
    endfunction

    function void note_request(req_kind_t kind, logic [3:0] ln, logic [63:0] jw);
      owed_results.push_back(predict(kind, ln, jw));
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(logic [1:0] st, logic [63:0] job, logic [3:0] src);
      lane_result_t want;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed (status %0d)", st));
      end else begin
        want = owed_results.pop_front();
        status_seen[want.status]++;
        if (st !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", st, want.status));
        if (job !== want.job)
          report_mismatch($sformatf("got_job %h, wanted %h", job, want.job));
        if (src !== want.src)
          report_mismatch($sformatf("source_lane %0d, wanted %0d", src, want.src));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = 1'b0;
  logic [3:0]  in_lane = '0;
  logic [63:0] in_job_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [63:0] out_got_job;
  logic [3:0]  out_source_lane;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  lane_queue_scoreboard sb;

  bit steady_feed    = 1'b0;   // no sender gaps while set
  bit long_hold_req  = 1'b0;   // ask the receiver for one long stall
  int requests_sent  = 0;
  int settings_used  = 0;

  work_stealing_lane_queues #(
    .NUM_LANES   (LANES),
    .QUEUE_DEPTH (DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_lane         (in_lane),
    .in_job_word     (in_job_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_got_job     (out_got_job),
    .out_source_lane (out_source_lane),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] pick_job();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return {$urandom, $urandom};
  endfunction

  // Offer one request transaction; call at a falling edge, returns at one.
  task automatic send_request(input req_kind_t kind, input logic [3:0] ln,
                              input logic [63:0] jw);
    int gap;
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_lane     <= ln;
    in_job_word <= jw;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, ln, jw);
    requests_sent++;
    @(negedge clk);
    gap = steady_feed ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Write the lane count; only called while the block is idle.
  task automatic write_lane_count(input logic [4:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_lanes(v);
    settings_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and hold until every owed result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random requests under one lane count. hot_lane >= 0 steers most pushes
  // to that lane so its queue fills.
  task automatic run_phase(input int n_items, input int push_pct, input int bad_pct,
                           input int hot_lane);
    req_kind_t   kind;
    logic [3:0]  ln;
    int unsigned count;
    for (int n = 0; n < n_items; n++) begin
      count = sb.live_lanes();
      kind  = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_ACQUIRE;
      if (count < LANES && $urandom_range(99) < bad_pct)
        ln = 4'($urandom_range(count, LANES - 1));
      else if (hot_lane >= 0 && kind == REQ_PUSH && $urandom_range(99) < 80)
        ln = 4'(hot_lane);
      else
        ln = 4'($urandom_range(count - 1));
      send_request(kind, ln, pick_job());
    end
    drain_results();
  endtask

  // Take every result the block offers and check it.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_got_job, out_source_lane);
  end

  // Receiver: random ready pattern, plus one long stall on request.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      int r;
      int len;
      @(negedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        r = $urandom_range(99);
        if (r < 65) begin
          out_ready <= 1'b1;
          len = $urandom_range(1, 20);
        end else if (r < 95) begin
          out_ready <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          out_ready <= 1'b0;
          len = $urandom_range(10, 40);
        end
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("Timeout with %0d results still owed", sb.outstanding());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset lane count of eight.
    send_request(REQ_ACQUIRE, 4'd0, '0);              // sweep over empty lanes
    send_request(REQ_PUSH,    4'd8, '1);              // bad lane
    send_request(REQ_ACQUIRE, 4'd15, '1);             // bad lane, acquire
    send_request(REQ_PUSH,    4'd0, '0);
    send_request(REQ_PUSH,    4'd0, '1);
    send_request(REQ_PUSH,    4'd7, 64'hA5A5_5A5A_F00D_C0DE);
    send_request(REQ_ACQUIRE, 4'd0, 64'h1234);        // own queue pop
    send_request(REQ_ACQUIRE, 4'd3, '0);              // steal
    send_request(REQ_ACQUIRE, 4'd3, '0);              // steal
    send_request(REQ_ACQUIRE, 4'd7, '0);              // nothing left
    drain_results();

    // Single lane: no generator step on an empty own queue.
    write_lane_count(5'd1);
    send_request(REQ_ACQUIRE, 4'd0, '0);
    send_request(REQ_PUSH,    4'd0, 64'h8000_0000_0000_0001);
    send_request(REQ_ACQUIRE, 4'd0, '0);
    send_request(REQ_PUSH,    4'd1, '1);
    drain_results();

    // Zero clamps up to one lane.
    write_lane_count(5'd0);
    send_request(REQ_ACQUIRE, 4'd0, '0);
    send_request(REQ_PUSH,    4'd2, '0);
    drain_results();

    // Oversized count clamps to all lanes.
    write_lane_count(5'd31);
    send_request(REQ_PUSH,    4'd15, '1);
    send_request(REQ_ACQUIRE, 4'd14, '0);
    send_request(REQ_ACQUIRE, 4'd15, '0);
    drain_results();

    // Random phases across lane counts.
    write_lane_count(5'd16);
    run_phase(100, 55, 0, -1);

    write_lane_count(5'd2);
    run_phase(80, 50, 15, -1);

    // Back-pressure: stall the receiver while the sender keeps offering.
    write_lane_count(5'd5);
    steady_feed   = 1'b1;
    long_hold_req = 1'b1;
    run_phase(80, 60, 10, -1);
    steady_feed   = 1'b0;

    // Fill lane zero past its depth.
    write_lane_count(5'd1);
    run_phase(300, 98, 5, 0);

    // Wide again: earlier jobs in the upper lanes reappear for stealing.
    write_lane_count(5'd31);
    run_phase(100, 40, 0, -1);

    write_lane_count(5'd12);
    steady_feed = 1'b1;
    run_phase(70, 50, 10, -1);
    steady_feed = 1'b0;

    write_lane_count(5'd0);
    run_phase(30, 50, 20, -1);

    write_lane_count(5'd8);
    run_phase(90, 45, 10, -1);

    // Let any stray result show up before closing out.
    repeat (60) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.outstanding()));

    $display("Ran %0d requests, %0d count writes: %0d done %0d full %0d empty %0d bad lane",
             requests_sent, settings_used, sb.status_seen[0], sb.status_seen[1],
             sb.status_seen[2], sb.status_seen[3]);
    $display("%0d acquires were served by stealing from another lane", sb.steals);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
